/* rtl/slmmm_pkg.sv */
// Shared constants, request codes and controller/datapath interface types.
package slmmm_pkg;

   // Number of words held in the sample ring.
   localparam int LOG_DEPTH = 16;

   // Field widths fixed by the interface.
   localparam int DATA_W = 32;
   localparam int SLOT_W = 8;

   // Ring index width; one bit at least so a single-entry ring still indexes.
   localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   // The running sum of all words never exceeds DATA_W + SLOT_W bits.
   localparam int SUM_W = DATA_W + SLOT_W;

   // Only words below this limit take part in the minimum search.
   localparam logic [DATA_W-1:0] MIN_LIMIT = DATA_W'(20000);

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_STORE = 2'd0,
      REQ_MAX   = 2'd1,
      REQ_MIN   = 2'd2,
      REQ_MEAN  = 2'd3
   } req_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_load;
      logic scan_init;
      logic store_wr;
      logic scan_rd;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_store;
      logic scan_last;
   } status_type;

endpackage

/* rtl/slmmm_datapath.sv */
// Datapath: sample ring memory, scan accumulators, mean shift, result register.
module slmmm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  slmmm_pkg::cmd_type                cmd,
   output slmmm_pkg::status_type             status,
   input  logic [1:0]                        req_type,
   input  logic [slmmm_pkg::DATA_W-1:0]      req_sample,
   output logic [slmmm_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [slmmm_pkg::DATA_W-1:0]      rsp_value
);

   localparam logic [slmmm_pkg::IDX_W-1:0] LAST_IDX =
      slmmm_pkg::IDX_W'(slmmm_pkg::LOG_DEPTH - 1);

   // Latched request word.
   slmmm_pkg::req_kind_type                 req_kind_ff;
   logic [slmmm_pkg::DATA_W-1:0]            sample_ff;

   // Ring storage, per-entry valid bits and write pointer.
   logic [slmmm_pkg::DATA_W-1:0]            mem [slmmm_pkg::LOG_DEPTH];
   logic [slmmm_pkg::LOG_DEPTH-1:0]         valid_ff;
   logic [slmmm_pkg::IDX_W-1:0]             write_slot_ff;

   // Scan address and registered read port.
   logic [slmmm_pkg::IDX_W-1:0]             idx_ff;
   logic                                    rd_pend_ff;
   logic [slmmm_pkg::IDX_W-1:0]             rd_idx_ff;
   logic [slmmm_pkg::DATA_W-1:0]            rd_data_ff;

   // Scan accumulators.
   logic [slmmm_pkg::DATA_W-1:0]            max_ff;
   logic [slmmm_pkg::IDX_W-1:0]             max_slot_ff;
   logic [slmmm_pkg::DATA_W-1:0]            min_ff;
   logic [slmmm_pkg::IDX_W-1:0]             min_slot_ff;
   logic [slmmm_pkg::DATA_W-1:0]            slot0_ff;

   // Sum of all ring words for the mean.
   logic [slmmm_pkg::SUM_W-1:0]             sum_ff;

   // Result register.
   logic [slmmm_pkg::SLOT_W-1:0]            rsp_slot_ff;
   logic [slmmm_pkg::DATA_W-1:0]            rsp_value_ff;

   // Next values.
   logic [slmmm_pkg::SUM_W-1:0]             mean_full;
   logic [slmmm_pkg::SLOT_W-1:0]            rsp_slot_in;
   logic [slmmm_pkg::DATA_W-1:0]            rsp_value_in;

   // The ring depth is a power of two, so the mean is a plain shift of the sum.
   assign mean_full = sum_ff / slmmm_pkg::SUM_W'(slmmm_pkg::LOG_DEPTH);

   // Result selection by request kind.
   always_comb begin
      case (req_kind_ff)
         slmmm_pkg::REQ_STORE: begin
            rsp_slot_in  = slmmm_pkg::SLOT_W'(write_slot_ff);
            rsp_value_in = sample_ff;
         end
         slmmm_pkg::REQ_MAX: begin
            rsp_slot_in  = slmmm_pkg::SLOT_W'(max_slot_ff);
            rsp_value_in = max_ff;
         end
         slmmm_pkg::REQ_MIN: begin
            // With no word below the limit the answer is slot 0 and its content.
            rsp_slot_in  = slmmm_pkg::SLOT_W'(min_slot_ff);
            rsp_value_in = (min_ff != slmmm_pkg::MIN_LIMIT) ? min_ff : slot0_ff;
         end
         default: begin
            rsp_slot_in  = '0;
            rsp_value_in = mean_full[slmmm_pkg::DATA_W-1:0];
         end
      endcase
   end

   // Control registers: pointer, valid bits and read pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         valid_ff      <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_rd;
         if (cmd.store_wr) begin
            valid_ff[write_slot_ff] <= 1'b1;
         end
         if (cmd.rsp_load && (req_kind_ff == slmmm_pkg::REQ_STORE)) begin
            write_slot_ff <= (write_slot_ff == LAST_IDX) ? '0 : write_slot_ff + 1'b1;
         end
      end
   end

   // Ring memory write and registered read; unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         mem[write_slot_ff] <= sample_ff;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= valid_ff[idx_ff] ? mem[idx_ff] : '0;
         rd_idx_ff  <= idx_ff;
      end
   end

   // Request latch and scan accumulators.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_kind_ff <= slmmm_pkg::req_kind_type'(req_type);
         sample_ff   <= req_sample;
      end
      if (cmd.scan_init) begin
         idx_ff      <= LAST_IDX;
         max_ff      <= '0;
         max_slot_ff <= '0;
         min_ff      <= slmmm_pkg::MIN_LIMIT;
         min_slot_ff <= '0;
         slot0_ff    <= '0;
         sum_ff      <= '0;
      end else begin
         if (cmd.scan_rd) begin
            idx_ff <= idx_ff - 1'b1;
         end
         // Scan runs from the top slot down; strict compares keep the highest slot on ties.
         if (rd_pend_ff) begin
            if (rd_data_ff > max_ff) begin
               max_ff      <= rd_data_ff;
               max_slot_ff <= rd_idx_ff;
            end
            if (rd_data_ff < min_ff) begin
               min_ff      <= rd_data_ff;
               min_slot_ff <= rd_idx_ff;
            end
            if (rd_idx_ff == '0) begin
               slot0_ff <= rd_data_ff;
            end
            sum_ff <= sum_ff + slmmm_pkg::SUM_W'(rd_data_ff);
         end
      end
      if (cmd.rsp_load) begin
         rsp_slot_ff  <= rsp_slot_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   // Status back to the controller.
   always_comb begin
      status.is_store  = (req_kind_ff == slmmm_pkg::REQ_STORE);
      status.scan_last = (idx_ff == '0);
   end

   assign rsp_slot  = rsp_slot_ff;
   assign rsp_value = rsp_value_ff;

endmodule

/* rtl/slmmm_ctrl.sv */
// Controller: sequences store, scan and result hand-off.
module slmmm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output slmmm_pkg::cmd_type     cmd,
   input  slmmm_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.req_load  = req_accept;
      cmd.scan_init = req_accept;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_store) begin
               cmd.store_wr = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared when the receiver takes the word.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/sample_log_min_max_mean_unit.sv */
// Top level of the sample log with maximum, minimum and mean queries.
//
// Request channel (req_valid/req_stall): one word carries req_type and
// req_sample. Type 0 stores the sample in the ring at the write slot, 1 asks
// for the largest word, 2 for the smallest word below 20000, 3 for the mean.
// Response channel (rsp_valid/rsp_stall): one word per request with rsp_slot
// and rsp_value, held in an output register until the receiver takes it.
// Maximum, minimum and mean queries scan the ring with one ring read per cycle
// through a single registered memory port; the mean divides the sum by the
// power-of-two depth with a shift.
// One request is in flight at a time; the next is taken the cycle after its
// result is loaded. A stalled response only delays the following request once
// that request's result is ready.
// Reset clears the write slot and every per-entry valid bit, so the ring reads
// as all zero, and empties the output register.
module sample_log_min_max_mean_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [slmmm_pkg::DATA_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [slmmm_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [slmmm_pkg::DATA_W-1:0]  rsp_value
);

   slmmm_pkg::cmd_type    cmd;
   slmmm_pkg::status_type status;

   // Sequencer.
   slmmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic.
   slmmm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_type),
      .req_sample (req_sample),
      .rsp_slot   (rsp_slot),
      .rsp_value  (rsp_value)
   );

   // An accepted request closes the input until its result is loaded.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open while a request is in flight");

   // A result is never loaded over one the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten before delivery");

   // Every reported slot lies inside the ring.
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot < slmmm_pkg::SLOT_W'(slmmm_pkg::LOG_DEPTH)))
      else $error("reported slot outside the ring");

endmodule

/* tb/sv/tb_sample_log_min_max_mean_unit.sv */
// Testbench for the sample log unit: predicts every answer and checks each result word.
`timescale 1ns / 100ps

module tb_sample_log_min_max_mean_unit;
   import slmmm_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 257;
   localparam int MAX_SHOWN       = 10;

   // One expected response word.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] value;
   } speed_answer_t;

   // Shadow copy of the ring plus the queue of answers still owed by the unit.
   class speed_log_board;
      logic [DATA_W-1:0] log_words [LOG_DEPTH];
      int unsigned       write_slot;
      speed_answer_t     owed_answers [$];
      int unsigned       mismatches;
      int unsigned       words_checked;
      int unsigned       kind_count [4];

      function new();
         foreach (log_words[i]) log_words[i] = '0;
         write_slot    = 0;
         mismatches    = 0;
         words_checked = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function int unsigned pending();
         return owed_answers.size();
      endfunction

      // Work out the answer for an accepted request and update the shadow ring.
      function void note_request(req_kind_type kind, logic [DATA_W-1:0] sample);
         speed_answer_t     answer;
         logic [DATA_W-1:0] best;
         logic [SUM_W-1:0]  total;
         int unsigned       where;

         answer = '0;
         where  = 0;
         kind_count[kind]++;
         case (kind)
            REQ_STORE: begin
               where = (write_slot >= LOG_DEPTH) ? 0 : write_slot;
               log_words[where] = sample;
               answer.value = sample;
               write_slot = (where + 1 >= LOG_DEPTH) ? 0 : where + 1;
            end
            REQ_MAX: begin
               // Scan from the top with a strict compare so the highest slot wins ties.
               best = '0;
               for (int i = LOG_DEPTH - 1; i >= 0; i--) begin
                  if (log_words[i] > best) begin
                     best  = log_words[i];
                     where = i;
                  end
               end
               answer.value = log_words[where];
            end
            REQ_MIN: begin
               // Only words below the limit qualify; with none, slot 0 is reported.
               best = MIN_LIMIT;
               for (int i = LOG_DEPTH - 1; i >= 0; i--) begin
                  if (log_words[i] < best) begin
                     best  = log_words[i];
                     where = i;
                  end
               end
               answer.value = log_words[where];
            end
            default: begin
               // The sum is kept at full width so the mean never wraps.
               total = '0;
               foreach (log_words[i]) total += SUM_W'(log_words[i]);
               total = total / LOG_DEPTH;
               answer.value = total[DATA_W-1:0];
               where = 0;
            end
         endcase
         answer.slot = SLOT_W'(where);
         owed_answers.push_back(answer);
      endfunction

      // Compare one accepted result word with the oldest owed answer.
      function void check_result(logic [SLOT_W-1:0] got_slot, logic [DATA_W-1:0] got_value);
         speed_answer_t owed;

         words_checked++;
         if (owed_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%0t: unexpected result word slot=%0d value=%h",
                        $realtime, got_slot, got_value);
            return;
         end
         owed = owed_answers.pop_front();
         if (got_slot !== owed.slot || got_value !== owed.value) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%0t: result word %0d mismatch: slot exp %0d got %0d, value exp %h got %h",
                        $realtime, words_checked, owed.slot, got_slot, owed.value, got_value);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_STORE;
   logic [DATA_W-1:0] req_sample = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [SLOT_W-1:0] rsp_slot;
   logic [DATA_W-1:0] rsp_value;

   int unsigned    cycle_count   = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    rsp_stall_pct = 0;
   speed_log_board board = new();

   sample_log_min_max_mean_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_slot   (rsp_slot),
      .rsp_value  (rsp_value)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter for the watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a run that hangs ends here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d answers owed.", cycle_count, board.pending());
      $display("FAILURE");
      $finish;
   end

   // Result side: check each accepted word, then choose the next stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_slot, rsp_value);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Offer one request word, with random idle cycles first, and wait until it is taken.
   task automatic send_request(req_kind_type kind, logic [DATA_W-1:0] sample);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(kind, sample);
   endtask

   // Speed values biased toward the minimum limit, repeated values and the extremes.
   function automatic logic [DATA_W-1:0] pick_speed();
      case ($urandom_range(0, 9))
         0, 1, 2: return DATA_W'($urandom_range(0, 19999));
         3, 4:    return DATA_W'($urandom_range(19990, 20010));
         5, 6:    return DATA_W'($urandom_range(0, 3) * 5000 + 4999);
         7, 8:    return DATA_W'($urandom);
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   // Request mix: half stores, the rest spread over the three queries.
   function automatic req_kind_type pick_kind();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return REQ_STORE;
         5, 6:          return REQ_MAX;
         7, 8:          return REQ_MIN;
         default:       return REQ_MEAN;
      endcase
   endfunction

   initial begin
      int unsigned  idle_plan [4];
      int unsigned  stall_plan [4];
      req_kind_type kind;

      idle_plan  = '{0, 65, 0, 21};
      stall_plan = '{0, 0, 65, 21};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Queries on the empty log: max and min fall back, mean is zero.
      send_request(REQ_MAX, '1);
      send_request(REQ_MIN, '0);
      send_request(REQ_MEAN, 32'hA5A5_5A5A);

      // Fill the whole ring with the largest value: widest sum, all-way ties,
      // and no word below the minimum limit.
      for (int i = 0; i < LOG_DEPTH; i++) send_request(REQ_STORE, '1);
      send_request(REQ_MEAN, '0);
      send_request(REQ_MAX, '0);
      send_request(REQ_MIN, '1);

      // Words exactly at and just below the minimum limit, after the slot wraps.
      send_request(REQ_STORE, MIN_LIMIT);
      send_request(REQ_STORE, MIN_LIMIT - 1);
      send_request(REQ_MIN, '0);

      // Random requests under each idle and stall pattern.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         rsp_stall_pct = stall_plan[phase];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = pick_kind();
            send_request(kind, (kind == REQ_STORE) ? pick_speed() : DATA_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow time for any stray word to show up.
      while (board.pending() != 0) @(posedge clock);
      repeat (LOG_DEPTH + 64) @(posedge clock);

      $display("Covered %0d stores, %0d max, %0d min and %0d mean queries; %0d words checked.",
               board.kind_count[REQ_STORE], board.kind_count[REQ_MAX],
               board.kind_count[REQ_MIN], board.kind_count[REQ_MEAN], board.words_checked);
      $display("Mismatches: %0d, answers still owed: %0d.", board.mismatches, board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/slmmm_pkg.sv
rtl/slmmm_datapath.sv
rtl/slmmm_ctrl.sv
rtl/sample_log_min_max_mean_unit.sv
tb/sv/tb_sample_log_min_max_mean_unit.sv
